// ----- design/vap_pkg.sv -----
// ----------------------------------------------------------------------------
// vap_pkg
// Shared types and constants for the volume-at-price profile core.
// ----------------------------------------------------------------------------
package vap_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int PRICE_W  = 32;
	localparam int SIZE_W   = 24;
	localparam int TIME_W   = 32;
	localparam int VOL_W    = 32;
	localparam int WIN_W    = 16;
	localparam int SLOT_W   = 8;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd60;

	typedef enum logic [1:0] {
		SIDE_NONE = 2'd0,
		SIDE_BUY  = 2'd1,
		SIDE_SELL = 2'd2,
		SIDE_RSVD = 2'd3
	} side_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_PRICE = 2'd1,
		ST_FULL     = 2'd2,
		ST_RSVD     = 2'd3
	} result_status_t;

	// one stored price level
	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [VOL_W-1:0]   recent_ask;
		logic [VOL_W-1:0]   total_ask;
		logic [VOL_W-1:0]   recent_bid;
		logic [VOL_W-1:0]   total_bid;
		logic [TIME_W-1:0]  last_time;
	} level_t;

	localparam int LEVEL_W = $bits(level_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_INS,
		S_SHR,
		S_SHW,
		S_RDP,
		S_UPD_HIT,
		S_UPD_NEW,
		S_ERR_PRICE,
		S_ERR_FULL
	} ctrl_state_t;

	typedef enum logic [1:0] {
		RA_IDX,
		RA_JM1,
		RA_POS
	} rd_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    idx_inc;
		rd_sel_t rd_sel;
		logic    pos_from_idx;
		logic    pos_from_count;
		logic    wr_shift;
		logic    upd_hit;
		logic    upd_new;
		logic    err_price;
		logic    err_full;
	} vap_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_price_valid;
		logic idx_at_count;
		logic price_eq;
		logic price_gt;
		logic table_full;
		logic j_at_pos;
	} vap_stat_t;

endpackage

// ----- design/vap_ram.sv -----
// ----------------------------------------------------------------------------
// vap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vap_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- design/vap_ctrl.sv -----
// ----------------------------------------------------------------------------
// vap_ctrl
// Sequencer: scans the sorted table, opens a gap for a new price, then
// updates the level and issues the result.
// ----------------------------------------------------------------------------
module vap_ctrl import vap_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  vap_stat_t stat,
	output vap_cmd_t  cmd,
	output logic      busy
);

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_nx = S_RD;
			end
			S_RD: begin
				if (!stat.in_price_valid) state_nx = S_ERR_PRICE;
				else if (stat.idx_at_count) state_nx = S_INS;
				else state_nx = S_CMP;
			end
			S_CMP: begin
				if (stat.price_eq) state_nx = S_RDP;
				else if (stat.price_gt) state_nx = S_INS;
				else state_nx = S_RD;
			end
			S_INS: begin
				if (stat.table_full) state_nx = S_ERR_FULL;
				else state_nx = S_SHR;
			end
			S_SHR: begin
				if (stat.j_at_pos) state_nx = S_UPD_NEW;
				else state_nx = S_SHW;
			end
			S_SHW:       state_nx = S_SHR;
			S_RDP:       state_nx = S_UPD_HIT;
			S_UPD_HIT:   state_nx = S_IDLE;
			S_UPD_NEW:   state_nx = S_IDLE;
			S_ERR_PRICE: state_nx = S_IDLE;
			S_ERR_FULL:  state_nx = S_IDLE;
			default:     state_nx = S_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd = '0;
		cmd.rd_sel = RA_IDX;
		case (state_q)
			S_IDLE: cmd.load = start;
			S_RD: cmd.rd_sel = RA_IDX;
			S_CMP: begin
				cmd.idx_inc      = !stat.price_eq && !stat.price_gt;
				cmd.pos_from_idx = stat.price_eq || stat.price_gt;
			end
			S_INS: cmd.pos_from_count = 1'b1;
			S_SHR: cmd.rd_sel = RA_JM1;
			S_SHW: cmd.wr_shift = 1'b1;
			S_RDP: cmd.rd_sel = RA_POS;
			S_UPD_HIT: cmd.upd_hit = 1'b1;
			S_UPD_NEW: cmd.upd_new = 1'b1;
			S_ERR_PRICE: cmd.err_price = 1'b1;
			S_ERR_FULL: cmd.err_full = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- design/vap_dp.sv -----
// ----------------------------------------------------------------------------
// vap_dp
// Datapath: trade registers, scan/shift counters, level table RAM,
// window test, saturating adders and result registers.
// ----------------------------------------------------------------------------
module vap_dp import vap_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vap_cmd_t           cmd,
	output vap_stat_t          stat,
	input  logic               price_valid,
	input  logic [PRICE_W-1:0] price_ticks,
	input  logic [SIZE_W-1:0]  trade_size,
	input  logic [TIME_W-1:0]  trade_time,
	input  logic [1:0]         aggressor_side,
	input  logic               cfg_valid,
	input  logic [WIN_W-1:0]   cfg_data,
	output logic               result_valid,
	output logic [1:0]         status,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [VOL_W-1:0]   recent_ask_volume,
	output logic [VOL_W-1:0]   total_ask_volume,
	output logic [VOL_W-1:0]   recent_bid_volume,
	output logic [VOL_W-1:0]   total_bid_volume
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic               pvalid_q;
	logic [PRICE_W-1:0] price_q;
	logic [SIZE_W-1:0]  size_q;
	logic [TIME_W-1:0]  time_q;
	side_t              side_q;
	logic [WIN_W-1:0]   window_q;
	logic [CW-1:0]      count_q, idx_q, pos_q, j_q;

	logic [AW-1:0]      rd_addr, wr_addr;
	logic               wr_en;
	level_t             wr_level, rd_level, base, upd;
	logic [CW-1:0]      jm1;
	logic               stale;
	logic [TIME_W-1:0]  age;

	// trade capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pvalid_q <= price_valid;
			price_q  <= price_ticks;
			size_q   <= trade_size;
			time_q   <= trade_time;
			side_q   <= side_t'(aggressor_side);
		end
	end

	// window register, table fill and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			count_q  <= '0;
			idx_q    <= '0;
			pos_q    <= '0;
			j_q      <= '0;
		end else begin
			if (cfg_valid) window_q <= cfg_data;
			if (cmd.load) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.pos_from_idx) pos_q <= idx_q;
			if (cmd.pos_from_count) begin
				j_q <= count_q;
				if (idx_q == count_q) pos_q <= count_q;
			end else if (cmd.wr_shift) begin
				j_q <= jm1;
			end
			if (cmd.upd_new) count_q <= count_q + 1'b1;
		end
	end

	assign jm1 = j_q - 1'b1;

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			RA_IDX:  rd_addr = idx_q[AW-1:0];
			RA_JM1:  rd_addr = jm1[AW-1:0];
			RA_POS:  rd_addr = pos_q[AW-1:0];
			default: rd_addr = idx_q[AW-1:0];
		endcase
	end

	// level update: window clear, time store, saturating adds
	always_comb begin
		logic [VOL_W:0] s_ra, s_ta, s_rb, s_tb;
		if (cmd.upd_new) begin
			base = '0;
			base.price = price_q;
		end else begin
			base = rd_level;
		end
		age   = time_q - base.last_time;
		stale = (time_q > base.last_time) && (age > TIME_W'(window_q));
		upd = base;
		if (stale) begin
			upd.recent_ask = '0;
			upd.recent_bid = '0;
		end
		upd.last_time = time_q;
		s_ra = {1'b0, upd.recent_ask} + (VOL_W + 1)'(size_q);
		s_ta = {1'b0, upd.total_ask}  + (VOL_W + 1)'(size_q);
		s_rb = {1'b0, upd.recent_bid} + (VOL_W + 1)'(size_q);
		s_tb = {1'b0, upd.total_bid}  + (VOL_W + 1)'(size_q);
		if (side_q == SIDE_BUY) begin
			upd.recent_ask = s_ra[VOL_W] ? '1 : s_ra[VOL_W-1:0];
			upd.total_ask  = s_ta[VOL_W] ? '1 : s_ta[VOL_W-1:0];
		end else if (side_q == SIDE_SELL) begin
			upd.recent_bid = s_rb[VOL_W] ? '1 : s_rb[VOL_W-1:0];
			upd.total_bid  = s_tb[VOL_W] ? '1 : s_tb[VOL_W-1:0];
		end
	end

	// write port: shift beats move an entry up one slot
	always_comb begin
		wr_en    = cmd.wr_shift || cmd.upd_hit || cmd.upd_new;
		wr_addr  = cmd.wr_shift ? j_q[AW-1:0] : pos_q[AW-1:0];
		wr_level = cmd.wr_shift ? rd_level : upd;
	end

	vap_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_level),
		.rd_addr (rd_addr),
		.rd_data (rd_level)
	);

	// status to controller
	always_comb begin
		stat.in_price_valid = pvalid_q;
		stat.idx_at_count   = (idx_q == count_q);
		stat.price_eq       = (rd_level.price == price_q);
		stat.price_gt       = (rd_level.price > price_q);
		stat.table_full     = (count_q == DEPTH_C);
		stat.j_at_pos       = (j_q == pos_q);
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.upd_hit || cmd.upd_new || cmd.err_price || cmd.err_full;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.upd_hit || cmd.upd_new) begin
			status            <= ST_OK;
			slot_index        <= SLOT_W'(pos_q);
			recent_ask_volume <= upd.recent_ask;
			total_ask_volume  <= upd.total_ask;
			recent_bid_volume <= upd.recent_bid;
			total_bid_volume  <= upd.total_bid;
		end else if (cmd.err_price || cmd.err_full) begin
			status            <= cmd.err_price ? ST_NO_PRICE : ST_FULL;
			slot_index        <= '0;
			recent_ask_volume <= '0;
			total_ask_volume  <= '0;
			recent_bid_volume <= '0;
			total_bid_volume  <= '0;
		end
	end

endmodule

// ----- design/volume_at_price_profile_core.sv -----
// ----------------------------------------------------------------------------
// volume_at_price_profile_core
// Price-sorted volume-at-price table updated one trade at a time.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------
//  trade    | start / busy           | price_valid, price_ticks, trade_size,
//           |                        | trade_time, aggressor_side
//  result   | result_valid (strobe)  | status, slot_index, 4 volume fields
//  config   | cfg_valid / cfg_ready  | cfg_data (recent window, seconds)
//
// Each trade runs a linear scan of the sorted table; a new price inserted
// below the top then opens its gap with a one-slot-per-beat shift through
// the single table RAM port, while an appended price needs no shift. A
// trade with no price ends before any comparison; a full table is reported
// once the scan stops. The result strobe comes in the first cycle with busy low.
// Reset clears the level count and sets the window to 60; table contents
// need no clearing. Results are one-cycle strobes and cannot be stalled;
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module volume_at_price_profile_core import vap_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               price_valid,
	input  logic [PRICE_W-1:0] price_ticks,
	input  logic [SIZE_W-1:0]  trade_size,
	input  logic [TIME_W-1:0]  trade_time,
	input  logic [1:0]         aggressor_side,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WIN_W-1:0]   cfg_data,
	output logic               result_valid,
	output logic [1:0]         status,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [VOL_W-1:0]   recent_ask_volume,
	output logic [VOL_W-1:0]   total_ask_volume,
	output logic [VOL_W-1:0]   recent_bid_volume,
	output logic [VOL_W-1:0]   total_bid_volume
);

	vap_cmd_t  cmd;
	vap_stat_t stat;
	logic      start_ok;

	assign cfg_ready = 1'b1;
	assign start_ok  = start && !busy;

	vap_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ok),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	vap_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.price_valid       (price_valid),
		.price_ticks       (price_ticks),
		.trade_size        (trade_size),
		.trade_time        (trade_time),
		.aggressor_side    (aggressor_side),
		.cfg_valid         (cfg_valid),
		.cfg_data          (cfg_data),
		.result_valid      (result_valid),
		.status            (status),
		.slot_index        (slot_index),
		.recent_ask_volume (recent_ask_volume),
		.total_ask_volume  (total_ask_volume),
		.recent_bid_volume (recent_bid_volume),
		.total_bid_volume  (total_bid_volume)
	);

endmodule
